### hw/rtl/dmph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmph_pkg: shared types and constants of the dual modular polynomial hash
// widths, register codes and reset values, controller states, datapath
// command and status structs
// ----------------------------------------------------------------------------
package dmph_pkg;

   localparam int DataW    = 64;
   localparam int CharW    = 16;
   localparam int CsrIdxW  = 3;
   localparam int CntW     = 6;

   // register indexes of the csr port
   localparam logic [CsrIdxW-1:0] CSR_MODULUS_A = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_BASE_A    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MODULUS_B = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_BASE_B    = 3'd3;

   // register defaults
   localparam logic [DataW-1:0] MODULUS_A_RESET = 64'd1000000007;
   localparam logic [DataW-1:0] BASE_A_RESET    = 64'd131;
   localparam logic [DataW-1:0] MODULUS_B_RESET = 64'd998244353;
   localparam logic [DataW-1:0] BASE_B_RESET    = 64'd137;

   // last counter value of each serial pass
   localparam logic [CntW-1:0] WORD_LAST_STEP = CntW'(DataW - 1);
   localparam logic [CntW-1:0] CHAR_LAST_STEP = CntW'(CharW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RED_H,
      ST_RED_C,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_LOAD_RH,
      DP_LOAD_RC,
      DP_RED,
      DP_LOAD_MUL,
      DP_MUL,
      DP_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      store_hr;
      logic      store_cr;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic need_h;
      logic need_c;
   } dp_status_type;

endpackage : dmph_pkg
`default_nettype wire

### hw/rtl/dmph_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmph_req_if: character channel
// valid/ready handshake carrying one character code and its last mark
// ----------------------------------------------------------------------------
interface dmph_req_if;
   logic                         valid;
   logic                         ready;
   logic [dmph_pkg::CharW-1:0]   char_code;
   logic                         last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface : dmph_req_if
`default_nettype wire

### hw/rtl/dmph_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmph_rsp_if: hash result channel
// valid/ready handshake carrying both final hashes of a string
// ----------------------------------------------------------------------------
interface dmph_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dmph_pkg::DataW-1:0]   hash_a;
   logic [dmph_pkg::DataW-1:0]   hash_b;

   modport source (output valid, output hash_a, output hash_b, input ready);
   modport sink   (input valid, input hash_a, input hash_b, output ready);
endinterface : dmph_rsp_if
`default_nettype wire

### hw/rtl/dual_modular_polynomial_hash_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_modular_polynomial_hash_top: two-lane polynomial string hash
// per character: acc = (acc * base + char) mod modulus in both lanes, with
// the exact product; the last character emits both hashes and then restarts the accumulators by clearing them
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  req       in         valid/ready      char_code[15:0], last_char
//  rsp       out        valid/ready      hash_a[63:0], hash_b[63:0]
//  csr       in         csr_we           csr_index[2:0], csr_wdata[63:0]
//
//  an item passes through accept, check, 64 multiply steps (one base bit
//  per cycle in each lane's serial modular multiplier) and the final add
//  an accumulator not below its modulus adds a serial remainder pass, and a
//  character not below its modulus adds one, each followed by a new check
//  reset (synchronous) clears both accumulators and loads the default
//  registers; a waiting result does not block the next item, only the
//  final step of the next last character waits for rsp to drain
//
module dual_modular_polynomial_hash_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   dmph_req_if.sink                           req,
   dmph_rsp_if.source                         rsp,
   input  wire logic                          csr_we,
   input  wire logic [dmph_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [dmph_pkg::DataW-1:0]    csr_wdata
);
   import dmph_pkg::*;

   // configuration registers
   logic [DataW-1:0] modulus_a_ff, modulus_a_in;
   logic [DataW-1:0] base_a_ff, base_a_in;
   logic [DataW-1:0] modulus_b_ff, modulus_b_in;
   logic [DataW-1:0] base_b_ff, base_b_in;

   dp_cmd_type    cmd;
   dp_status_type status_a;
   dp_status_type status_b;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   logic [DataW-1:0] hash_a;
   logic [DataW-1:0] hash_b;

   // out-of-range indexes are dropped
   always_comb begin
      modulus_a_in = modulus_a_ff;
      base_a_in    = base_a_ff;
      modulus_b_in = modulus_b_ff;
      base_b_in    = base_b_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS_A: modulus_a_in = csr_wdata;
            CSR_BASE_A:    base_a_in    = csr_wdata;
            CSR_MODULUS_B: modulus_b_in = csr_wdata;
            CSR_BASE_B:    base_b_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_a_ff <= MODULUS_A_RESET;
         base_a_ff    <= BASE_A_RESET;
         modulus_b_ff <= MODULUS_B_RESET;
         base_b_ff    <= BASE_B_RESET;
      end else begin
         modulus_a_ff <= modulus_a_in;
         base_a_ff    <= base_a_in;
         modulus_b_ff <= modulus_b_in;
         base_b_ff    <= base_b_in;
      end
   end

   // both lanes run in lockstep, so a reduction pass needed by either runs
   // in both (reducing a value already below its modulus leaves it alone)
   assign status.need_h = status_a.need_h || status_b.need_h;
   assign status.need_c = status_a.need_c || status_b.need_c;

   dmph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_char),
      .rsp_ready (rsp.ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dmph_lane u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .char_code (req.char_code),
      .modulus   (modulus_a_ff),
      .base      (base_a_ff),
      .status    (status_a),
      .hash      (hash_a)
   );

   dmph_lane u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .char_code (req.char_code),
      .modulus   (modulus_b_ff),
      .base      (base_b_ff),
      .status    (status_b),
      .hash      (hash_b)
   );

   assign req.ready  = req_ready;
   assign rsp.valid  = rsp_valid;
   assign rsp.hash_a = hash_a;
   assign rsp.hash_b = hash_b;

endmodule : dual_modular_polynomial_hash_top
`default_nettype wire

### hw/rtl/dmph_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmph_lane: one hash lane datapath
// bit-serial remainder and interleaved modular multiply, accumulator and
// result register; a zero modulus acts as 2^64
// ----------------------------------------------------------------------------
module dmph_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dmph_pkg::dp_cmd_type        cmd,
   input  wire logic [dmph_pkg::CharW-1:0]  char_code,
   input  wire logic [dmph_pkg::DataW-1:0]  modulus,
   input  wire logic [dmph_pkg::DataW-1:0]  base,
   output dmph_pkg::dp_status_type          status,
   output logic [dmph_pkg::DataW-1:0]       hash
);
   import dmph_pkg::*;

   logic [DataW-1:0] acc_ff, acc_in;
   logic [DataW-1:0] r_ff, r_in;
   logic [DataW-1:0] sh_ff, sh_in;
   logic [DataW-1:0] hr_ff, hr_in;
   logic [DataW-1:0] cr_ff, cr_in;
   logic [DataW-1:0] hash_ff, hash_in;

   logic [DataW:0]   mod_ext;
   logic [DataW:0]   red_t;
   logic [DataW+1:0] red_d;
   logic [DataW-1:0] red_next;
   logic [DataW-1:0] mul_add;
   logic [DataW+1:0] mul_t;
   logic [DataW+2:0] mul_d1;
   logic [DataW+2:0] mul_d2;
   logic [DataW-1:0] mul_next;
   logic [DataW:0]   fin_t;
   logic [DataW+1:0] fin_d;
   logic [DataW-1:0] fin_next;

   assign mod_ext = (modulus == '0) ? {1'b1, {DataW{1'b0}}} : {1'b0, modulus};

   // remainder step: (2r + next bit) mod m
   assign red_t    = {r_ff, sh_ff[DataW-1]};
   assign red_d    = {1'b0, red_t} - {1'b0, mod_ext};
   assign red_next = red_d[DataW+1] ? red_t[DataW-1:0] : red_d[DataW-1:0];

   // multiply step: (2r + bit * hr) mod m, below 3m before correction
   assign mul_add = sh_ff[DataW-1] ? hr_ff : '0;
   assign mul_t   = {1'b0, r_ff, 1'b0} + {2'b00, mul_add};
   assign mul_d1  = {1'b0, mul_t} - {2'b00, mod_ext};
   assign mul_d2  = {1'b0, mul_t} - {1'b0, mod_ext, 1'b0};

   always_comb begin
      priority if (!mul_d2[DataW+2]) begin
         mul_next = mul_d2[DataW-1:0];
      end else if (!mul_d1[DataW+2]) begin
         mul_next = mul_d1[DataW-1:0];
      end else begin
         mul_next = mul_t[DataW-1:0];
      end
   end

   // final add of the reduced character
   assign fin_t    = {1'b0, r_ff} + {1'b0, cr_ff};
   assign fin_d    = {1'b0, fin_t} - {1'b0, mod_ext};
   assign fin_next = fin_d[DataW+1] ? fin_t[DataW-1:0] : fin_d[DataW-1:0];

   assign status.need_h = ({1'b0, hr_ff} >= mod_ext);
   assign status.need_c = ({1'b0, cr_ff} >= mod_ext);
   assign hash          = hash_ff;

   always_comb begin
      acc_in  = acc_ff;
      r_in    = r_ff;
      sh_in   = sh_ff;
      hr_in   = hr_ff;
      cr_in   = cr_ff;
      hash_in = hash_ff;
      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_CAPTURE: begin
            hr_in = acc_ff;
            cr_in = {{(DataW-CharW){1'b0}}, char_code};
         end
         DP_LOAD_RH: begin
            r_in  = '0;
            sh_in = hr_ff;
         end
         DP_LOAD_RC: begin
            r_in  = '0;
            sh_in = {cr_ff[CharW-1:0], {(DataW-CharW){1'b0}}};
         end
         DP_RED: begin
            r_in  = red_next;
            sh_in = {sh_ff[DataW-2:0], 1'b0};
            if (cmd.store_hr) begin
               hr_in = red_next;
            end
            if (cmd.store_cr) begin
               cr_in = red_next;
            end
         end
         DP_LOAD_MUL: begin
            r_in  = '0;
            sh_in = base;
         end
         DP_MUL: begin
            r_in  = mul_next;
            sh_in = {sh_ff[DataW-2:0], 1'b0};
         end
         DP_FIN: begin
            if (cmd.last) begin
               hash_in = fin_next;
               acc_in  = '0;
            end else begin
               acc_in  = fin_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      sh_ff   <= sh_in;
      hr_ff   <= hr_in;
      cr_ff   <= cr_in;
      hash_ff <= hash_in;
   end

endmodule : dmph_lane
`default_nettype wire

### hw/rtl/dmph_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmph_ctrl: sequencer of the hash lanes
// steps both lanes through capture, optional reductions, the 64-step
// multiply and the final add; owns the result valid flag
// ----------------------------------------------------------------------------
module dmph_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_last,
   input  wire logic                     rsp_ready,
   input  wire dmph_pkg::dp_status_type  status,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output dmph_pkg::dp_cmd_type          cmd
);
   import dmph_pkg::*;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            last_ff, last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_busy;
   logic            fin_go;

   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign fin_go    = (state_ff == ST_FIN) && !(last_ff && rsp_busy);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_last;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            priority if (status.need_h) begin
               state_in = ST_RED_H;
            end else if (status.need_c) begin
               state_in = ST_RED_C;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_RED_H: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WORD_LAST_STEP) begin
               state_in = ST_CHECK;
            end
         end
         ST_RED_C: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CHAR_LAST_STEP) begin
               state_in = ST_CHECK;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WORD_LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      priority if (fin_go && last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = DP_NOP;
      cmd.store_hr = 1'b0;
      cmd.store_cr = 1'b0;
      cmd.last     = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_CAPTURE;
            end
         end
         ST_CHECK: begin
            priority if (status.need_h) begin
               cmd.op = DP_LOAD_RH;
            end else if (status.need_c) begin
               cmd.op = DP_LOAD_RC;
            end else begin
               cmd.op = DP_LOAD_MUL;
            end
         end
         ST_RED_H: begin
            cmd.op       = DP_RED;
            cmd.store_hr = (cnt_ff == WORD_LAST_STEP);
         end
         ST_RED_C: begin
            cmd.op       = DP_RED;
            cmd.store_cr = (cnt_ff == CHAR_LAST_STEP);
         end
         ST_MUL: begin
            cmd.op = DP_MUL;
         end
         ST_FIN: begin
            if (fin_go) begin
               cmd.op = DP_FIN;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule : dmph_ctrl
`default_nettype wire
